[rtl/sse_pkg.sv]
// shared types, register indexes and byte helpers for the substring search engine
package sse_pkg;

    localparam int PATTERN_WORDS = 4;
    localparam int WORD_BITS     = 64;
    localparam int LEN_BITS      = 6;
    localparam int OUT_POS_BITS  = 32;
    localparam int COUNT_BITS    = 32;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_WORD0   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_WORD1   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_WORD2   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_WORD3   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_LENGTH  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_SEARCH_MODE     = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_SEARCH_OPTIONS  = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_START_POSITION  = 3'd7;

    localparam int OPT_FOLD = 0;
    localparam int OPT_WRAP = 1;

    typedef enum logic [1:0] {
        MODE_FORWARD  = 2'd0,
        MODE_BACKWARD = 2'd1,
        MODE_COUNT    = 2'd2
    } search_mode_e;

    typedef struct packed {
        logic [PATTERN_WORDS-1:0][WORD_BITS-1:0] pattern_word;
        logic [LEN_BITS-1:0]                     pattern_length;
        logic [1:0]                              search_mode;
        logic [1:0]                              search_options;
        logic [OUT_POS_BITS-1:0]                 start_position;
    } cfg_t;

    typedef struct packed {
        logic [7:0] doc_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic                    found;
        logic [OUT_POS_BITS-1:0] match_position;
        logic [COUNT_BITS-1:0]   match_count;
    } out_beat_t;

    // control of the compare stage, handed from the window to the tracker
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic on);
        logic [7:0] r;
        r = c;
        if (on && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // bytes beyond the four pattern words read as zero
    function automatic logic [7:0] pattern_byte(
        input logic [PATTERN_WORDS-1:0][WORD_BITS-1:0] w,
        input logic [LEN_BITS-1:0]                     idx
    );
        logic [7:0] r;
        r = 8'd0;
        if (!idx[5]) begin
            r = w[idx[4:3]][idx[2:0]*8 +: 8];
        end
        return r;
    endfunction

endpackage

[rtl/substring_search_engine_unit.sv]
// top level of the streaming substring search engine
// Takes one document byte per beat and can sustain one beat every cycle. Each byte
// goes through a shift line of MAX_PATTERN bytes, is registered into the compare
// stage, compared against the pattern there and updates the match trackers when
// that stage is accepted; the beat carrying last_byte yields one result, held in an
// output register so the next document can keep streaming while the result waits.
// Input stalls only when a held result is not taken and the next last byte reaches
// the compare stage. Configuration goes through the plain write port and should be
// changed only between documents; there is no clearing pass after reset.
module substring_search_engine_unit #(
    parameter int MAX_PATTERN = 32,
    parameter int POS_BITS    = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [sse_pkg::REG_IDX_BITS-1:0]     cfg_index,
    input  logic [sse_pkg::WORD_BITS-1:0]        cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  sse_pkg::in_beat_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output sse_pkg::out_beat_t                   m_data
);
    import sse_pkg::*;

    cfg_t                        cfg_reg, cfg_next;
    stage_ctrl_t                 stage_ctrl;
    logic                        stage_ready;
    logic [POS_BITS-1:0]         stage_pos;
    logic [MAX_PATTERN-1:0][7:0] window;
    logic                        hit;
    logic [POS_BITS-1:0]         start_pos;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_WORD0:  cfg_next.pattern_word[0] = cfg_wr_data;
                REG_PATTERN_WORD1:  cfg_next.pattern_word[1] = cfg_wr_data;
                REG_PATTERN_WORD2:  cfg_next.pattern_word[2] = cfg_wr_data;
                REG_PATTERN_WORD3:  cfg_next.pattern_word[3] = cfg_wr_data;
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_wr_data[LEN_BITS-1:0];
                REG_SEARCH_MODE:    cfg_next.search_mode = cfg_wr_data[1:0];
                REG_SEARCH_OPTIONS: cfg_next.search_options = cfg_wr_data[1:0];
                REG_START_POSITION: cfg_next.start_position = cfg_wr_data[OUT_POS_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sse_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_BITS    (POS_BITS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .stage_ready (stage_ready),
        .stage_ctrl  (stage_ctrl),
        .stage_pos   (stage_pos),
        .window      (window)
    );

    sse_compare #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_BITS    (POS_BITS)
    ) u_compare (
        .window         (window),
        .pos            (stage_pos),
        .pattern_word   (cfg_reg.pattern_word),
        .pattern_length (cfg_reg.pattern_length),
        .fold_on        (cfg_reg.search_options[OPT_FOLD]),
        .hit            (hit),
        .start_pos      (start_pos)
    );

    sse_tracker #(
        .POS_BITS (POS_BITS)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage_ctrl  (stage_ctrl),
        .stage_ready (stage_ready),
        .hit         (hit),
        .start_pos   (start_pos),
        .cfg         (cfg_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[rtl/sse_window.sv]
// byte shift line, document position counter and compare stage register
module sse_window #(
    parameter int MAX_PATTERN = 32,
    parameter int POS_BITS    = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sse_pkg::in_beat_t                  s_data,
    input  logic                               stage_ready,
    output sse_pkg::stage_ctrl_t               stage_ctrl,
    output logic [POS_BITS-1:0]                stage_pos,
    output logic [MAX_PATTERN-1:0][7:0]        window
);
    import sse_pkg::*;

    logic [MAX_PATTERN-1:0][7:0] win_reg, win_next;
    logic [POS_BITS-1:0]         idx_reg, idx_next;
    logic [POS_BITS-1:0]         pos_reg, pos_next;
    stage_ctrl_t                 ctrl_reg, ctrl_next;
    logic                        s_fire;

    assign s_ready = !ctrl_reg.valid || stage_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        win_next  = win_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        ctrl_next = ctrl_reg;
        if (stage_ready) begin
            ctrl_next.valid = 1'b0;
        end
        if (s_fire) begin
            // older bytes never take part in a compare, so no clear between documents
            for (int k = MAX_PATTERN - 1; k > 0; k--) begin
                win_next[k] = win_reg[k-1];
            end
            win_next[0]     = s_data.doc_byte;
            pos_next        = idx_reg;
            ctrl_next.valid = 1'b1;
            ctrl_next.last  = s_data.last_byte;
            if (s_data.last_byte) begin
                idx_next = '0;
            end else if (idx_reg != '1) begin
                idx_next = idx_reg + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= '0;
            idx_reg  <= '0;
            ctrl_reg <= '0;
        end else begin
            win_reg  <= win_next;
            idx_reg  <= idx_next;
            ctrl_reg <= ctrl_next;
        end
        pos_reg <= pos_next;
    end

    assign stage_ctrl = ctrl_reg;
    assign stage_pos  = pos_reg;
    assign window     = win_reg;

endmodule

[rtl/sse_compare.sv]
// window against pattern compare, gives a hit and the match start offset
module sse_compare #(
    parameter int MAX_PATTERN = 32,
    parameter int POS_BITS    = 32
) (
    input  logic [MAX_PATTERN-1:0][7:0]                                     window,
    input  logic [POS_BITS-1:0]                                             pos,
    input  logic [sse_pkg::PATTERN_WORDS-1:0][sse_pkg::WORD_BITS-1:0]       pattern_word,
    input  logic [sse_pkg::LEN_BITS-1:0]                                    pattern_length,
    input  logic                                                            fold_on,
    output logic                                                            hit,
    output logic [POS_BITS-1:0]                                             start_pos
);
    import sse_pkg::*;

    localparam logic [LEN_BITS:0] MAX_LEN = (LEN_BITS+1)'(MAX_PATTERN);

    logic [MAX_PATTERN-1:0] byte_ok;
    logic [LEN_BITS:0]      len_x;
    logic [POS_BITS:0]      end_x;
    logic                   len_ok;

    assign len_x = {1'b0, pattern_length};
    assign end_x = {1'b0, pos} + (POS_BITS+1)'(1);

    // window[k] holds the byte k places back, it lines up with pattern byte len-1-k
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((LEN_BITS+1)'(k) < len_x) begin
                byte_ok[k] = fold_byte(window[k], fold_on) ==
                    fold_byte(pattern_byte(pattern_word,
                        LEN_BITS'(len_x - (LEN_BITS+1)'(1) - (LEN_BITS+1)'(k))), fold_on);
            end else begin
                byte_ok[k] = 1'b1;
            end
        end
    end

    assign len_ok = (pattern_length != '0) && (len_x <= MAX_LEN) &&
                    (end_x >= (POS_BITS+1)'(pattern_length));

    assign hit       = len_ok && (pos != '1) && (&byte_ok);
    assign start_pos = pos + POS_BITS'(1) - POS_BITS'(pattern_length);

endmodule

[rtl/sse_tracker.sv]
// match trackers, greedy counter and the result register
module sse_tracker #(
    parameter int POS_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sse_pkg::stage_ctrl_t             stage_ctrl,
    output logic                             stage_ready,
    input  logic                             hit,
    input  logic [POS_BITS-1:0]              start_pos,
    input  sse_pkg::cfg_t                    cfg,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sse_pkg::out_beat_t               m_data
);
    import sse_pkg::*;

    localparam int CMP_W = (POS_BITS > OUT_POS_BITS) ? POS_BITS : OUT_POS_BITS;

    logic                  fa_v_reg, fa_v_next, fs_v_reg, fs_v_next;
    logic                  lb_v_reg, lb_v_next, la_v_reg, la_v_next;
    logic [POS_BITS-1:0]   fa_p_reg, fa_p_next, fs_p_reg, fs_p_next;
    logic [POS_BITS-1:0]   lb_p_reg, lb_p_next, la_p_reg, la_p_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [POS_BITS-1:0]   nas_reg, nas_next;
    logic                  out_v_reg, out_v_next;
    out_beat_t             out_reg, out_next;
    logic                  fire;
    logic                  after_start;
    logic                  sel_v;
    logic [POS_BITS-1:0]   sel_p;
    logic [CMP_W-1:0]      sel_x;

    // the compare stage waits only when it holds the last byte and a result is still held at the output and not taken
    assign stage_ready = !(stage_ctrl.last && out_v_reg && !m_ready);
    assign fire        = stage_ctrl.valid && stage_ready;
    assign after_start = CMP_W'(start_pos) >= CMP_W'(cfg.start_position);

    always_comb begin
        fa_v_next  = fa_v_reg;
        fa_p_next  = fa_p_reg;
        fs_v_next  = fs_v_reg;
        fs_p_next  = fs_p_reg;
        lb_v_next  = lb_v_reg;
        lb_p_next  = lb_p_reg;
        la_v_next  = la_v_reg;
        la_p_next  = la_p_reg;
        cnt_next   = cnt_reg;
        nas_next   = nas_reg;
        if (fire && hit) begin
            if (!fa_v_reg) begin
                fa_v_next = 1'b1;
                fa_p_next = start_pos;
            end
            if (!fs_v_reg && after_start) begin
                fs_v_next = 1'b1;
                fs_p_next = start_pos;
            end
            if (!after_start) begin
                lb_v_next = 1'b1;
                lb_p_next = start_pos;
            end
            la_v_next = 1'b1;
            la_p_next = start_pos;
            if (start_pos >= nas_reg) begin
                if (cnt_reg != '1) begin
                    cnt_next = cnt_reg + COUNT_BITS'(1);
                end
                nas_next = start_pos + POS_BITS'(cfg.pattern_length);
            end
        end
    end

    // result select looks at the trackers including this beat's match
    always_comb begin
        sel_v = 1'b0;
        sel_p = '0;
        case (search_mode_e'(cfg.search_mode))
            MODE_FORWARD: begin
                sel_v = fs_v_next;
                sel_p = fs_p_next;
                if (!fs_v_next && cfg.search_options[OPT_WRAP]) begin
                    sel_v = fa_v_next;
                    sel_p = fa_p_next;
                end
            end
            MODE_BACKWARD: begin
                sel_v = lb_v_next;
                sel_p = lb_p_next;
                if (!lb_v_next && cfg.search_options[OPT_WRAP]) begin
                    sel_v = la_v_next;
                    sel_p = la_p_next;
                end
            end
            default: begin
                sel_v = 1'b0;
                sel_p = '0;
            end
        endcase
        sel_x = sel_v ? CMP_W'(sel_p) : '0;
    end

    always_comb begin
        out_next   = out_reg;
        out_v_next = out_v_reg;
        if (m_ready) begin
            out_v_next = 1'b0;
        end
        if (fire && stage_ctrl.last) begin
            out_v_next              = 1'b1;
            out_next.found          = sel_v;
            out_next.match_position = sel_x[OUT_POS_BITS-1:0];
            out_next.match_count    =
                (search_mode_e'(cfg.search_mode) == MODE_COUNT) ? cnt_next : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && stage_ctrl.last)) begin
            fa_v_reg <= 1'b0;
            fs_v_reg <= 1'b0;
            lb_v_reg <= 1'b0;
            la_v_reg <= 1'b0;
            cnt_reg  <= '0;
            nas_reg  <= '0;
        end else begin
            fa_v_reg <= fa_v_next;
            fs_v_reg <= fs_v_next;
            lb_v_reg <= lb_v_next;
            la_v_reg <= la_v_next;
            cnt_reg  <= cnt_next;
            nas_reg  <= nas_next;
        end
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
        end
        fa_p_reg <= fa_p_next;
        fs_p_reg <= fs_p_next;
        lb_p_reg <= lb_p_next;
        la_p_reg <= la_p_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

[rtl/sse_checker.sv]
// port level checks for the substring search engine and their bind
module sse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input sse_pkg::in_beat_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input sse_pkg::out_beat_t  m_data
);
    import sse_pkg::*;

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a find never reports a count and a count never reports a position
    a_mode_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.found && m_data.match_count != '0))
        else $error("found and count both set");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.match_position == '0)
        else $error("position set without a match");

    // input only stalls behind a result beat that is still waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a held result");

endmodule

bind substring_search_engine_unit sse_checker u_sse_checker (.*);
